// ===== src/rsa_pkg.sv =====
package rsa_pkg;

   // request field widths
   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 6;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 2'd2;

   // default ring depth
   localparam int DEFAULT_QUEUE_DEPTH = 32;

   // free-slot search is split into groups of this many slots
   localparam int GROUP_W     = 8;
   localparam int GROUP_IDX_W = 3;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } rsa_cmd_type;

endpackage

// ===== src/rsa_ctrl.sv =====
module rsa_ctrl
   import rsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FUNC_W-1:0] req_func,
   output logic              busy,
   output logic              rsp_strobe,
   output rsa_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   // state and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == S_COMMIT);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  // only an allocate needs the group search
                  state_ff <= (req_func == FUNC_ALLOC) ? S_SCAN : S_COMMIT;
               end
            end
            S_SCAN:   state_ff <= S_COMMIT;
            S_COMMIT: state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.scan    = (state_ff == S_SCAN);
      cmd.commit  = (state_ff == S_COMMIT);
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   // a response always follows a commit cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_COMMIT))
      else $error("response strobe without commit");

   // release, flush and no-op skip the search
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != FUNC_ALLOC) |=> (state_ff == S_COMMIT))
      else $error("non-allocate transaction went through search");

endmodule

// ===== src/rsa_datapath.sv =====
module rsa_datapath
   import rsa_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  rsa_cmd_type        cmd,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_granted,
   output logic [SLOT_W-1:0]  rsp_granted_slot,
   output logic [COUNT_W-1:0] rsp_free_slots,
   output logic               rsp_release_error,
   output logic [COUNT_W-1:0] rsp_pending_before_flush
);

   localparam int IW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int NG  = (QUEUE_DEPTH + GROUP_W - 1) / GROUP_W;
   localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
   localparam int PW  = NG * GROUP_W;

   // allocator state
   logic [QUEUE_DEPTH-1:0] used_ff, used_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          free_ff, free_in;

   // captured request
   logic [FUNC_W-1:0] func_ff;
   logic [SLOT_W-1:0] sidx_ff;

   // per-group search results
   logic [NG-1:0]          any_a_in, any_a_ff, any_m_in, any_m_ff;
   logic [GROUP_IDX_W-1:0] first_a_in [NG];
   logic [GROUP_IDX_W-1:0] first_a_ff [NG];
   logic [GROUP_IDX_W-1:0] first_m_in [NG];
   logic [GROUP_IDX_W-1:0] first_m_ff [NG];

   logic [QUEUE_DEPTH-1:0] free_vec;
   logic [PW-1:0]          pad_free, pad_mask;

   // group pick
   logic                   hit_a, hit_m, found;
   logic [GIW-1:0]         ga, gm, sel_g;
   logic [GROUP_IDX_W-1:0] ba, bm, sel_b;
   logic [GIW+GROUP_IDX_W-1:0] slot_pos;
   logic [IW-1:0]          alloc_slot;

   // release index
   logic [IW+SLOT_W-1:0] rel_wide;
   logic [IW-1:0]        rel_idx;
   logic                 rel_in_range;

   // response values
   logic                 granted_in, rerr_in;
   logic [IW-1:0]        gslot_in;
   logic [CW-1:0]        pending_in;
   logic [IW+SLOT_W-1:0] gslot_wide;
   logic [CW+COUNT_W-1:0] free_wide, pending_wide;

   logic               rsp_granted_ff, rsp_rerr_ff;
   logic [SLOT_W-1:0]  rsp_gslot_ff;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_pending_ff;

   // free bits, padded to whole groups, and those at or past the pointer
   assign free_vec = ~used_ff;
   assign pad_free = PW'(free_vec);

   always_comb begin
      for (int i = 0; i < PW; i++) begin
         pad_mask[i] = pad_free[i] && (i >= int'(ptr_ff));
      end
   end

   // first free slot within each group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         any_a_in[g]   = |pad_free[g*GROUP_W +: GROUP_W];
         any_m_in[g]   = |pad_mask[g*GROUP_W +: GROUP_W];
         first_a_in[g] = '0;
         first_m_in[g] = '0;
         for (int b = GROUP_W - 1; b >= 0; b--) begin
            if (pad_free[g*GROUP_W + b]) begin
               first_a_in[g] = GROUP_IDX_W'(b);
            end
            if (pad_mask[g*GROUP_W + b]) begin
               first_m_in[g] = GROUP_IDX_W'(b);
            end
         end
      end
   end

   // first group with a free slot, wrapping past the end of the ring
   always_comb begin
      ga = '0;
      gm = '0;
      ba = '0;
      bm = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (any_a_ff[g]) begin
            ga = GIW'(g);
            ba = first_a_ff[g];
         end
         if (any_m_ff[g]) begin
            gm = GIW'(g);
            bm = first_m_ff[g];
         end
      end
      hit_a = |any_a_ff;
      hit_m = |any_m_ff;
      found = hit_a || hit_m;
      sel_g = hit_m ? gm : ga;
      sel_b = hit_m ? bm : ba;
   end

   assign slot_pos   = {sel_g, sel_b};
   assign alloc_slot = slot_pos[IW-1:0];

   // release slot index
   assign rel_wide     = (IW + SLOT_W)'(sidx_ff);
   assign rel_idx      = rel_wide[IW-1:0];
   assign rel_in_range = (int'(sidx_ff) < QUEUE_DEPTH);

   // next state and response for the committed transaction
   always_comb begin
      used_in    = used_ff;
      ptr_in     = ptr_ff;
      free_in    = free_ff;
      granted_in = 1'b0;
      gslot_in   = '0;
      rerr_in    = 1'b0;
      pending_in = '0;
      case (func_ff)
         FUNC_ALLOC: begin
            if (found) begin
               used_in[alloc_slot] = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - CW'(1);
               end
               ptr_in     = alloc_slot;
               granted_in = 1'b1;
               gslot_in   = alloc_slot;
            end
         end
         FUNC_RELEASE: begin
            if (rel_in_range && used_ff[rel_idx]) begin
               used_in[rel_idx] = 1'b0;
               if (free_ff != CW'(QUEUE_DEPTH)) begin
                  free_in = free_ff + CW'(1);
               end
            end else begin
               rerr_in = 1'b1;
            end
         end
         FUNC_FLUSH: begin
            pending_in = CW'(QUEUE_DEPTH) - free_ff;
            used_in    = '0;
            ptr_in     = '0;
            free_in    = CW'(QUEUE_DEPTH);
         end
         default: ;
      endcase
   end

   assign gslot_wide   = (IW + SLOT_W)'(gslot_in);
   assign free_wide    = (CW + COUNT_W)'(free_in);
   assign pending_wide = (CW + COUNT_W)'(pending_in);

   // allocator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         ptr_ff  <= '0;
         free_ff <= CW'(QUEUE_DEPTH);
      end else if (cmd.commit) begin
         used_ff <= used_in;
         ptr_ff  <= ptr_in;
         free_ff <= free_in;
      end
   end

   // request capture, search results and response registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         sidx_ff <= req_slot_index;
      end
      if (cmd.scan) begin
         any_a_ff   <= any_a_in;
         any_m_ff   <= any_m_in;
         first_a_ff <= first_a_in;
         first_m_ff <= first_m_in;
      end
      if (cmd.commit) begin
         rsp_granted_ff <= granted_in;
         rsp_gslot_ff   <= gslot_wide[SLOT_W-1:0];
         rsp_free_ff    <= free_wide[COUNT_W-1:0];
         rsp_rerr_ff    <= rerr_in;
         rsp_pending_ff <= pending_wide[COUNT_W-1:0];
      end
   end

   assign rsp_granted              = rsp_granted_ff;
   assign rsp_granted_slot         = rsp_gslot_ff;
   assign rsp_free_slots           = rsp_free_ff;
   assign rsp_release_error        = rsp_rerr_ff;
   assign rsp_pending_before_flush = rsp_pending_ff;

   // free count always matches the used bitmap
   assert property (@(posedge clock) disable iff (reset)
      ($countones(used_ff) + int'(free_ff)) == QUEUE_DEPTH)
      else $error("free count out of step with used bitmap");

   // a granted allocate leaves the pointer on the granted slot
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == FUNC_ALLOC && found) |=>
         (ptr_ff == $past(alloc_slot) && used_ff[ptr_ff]))
      else $error("pointer not on granted slot");

   // a rejected release leaves the bitmap alone
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == FUNC_RELEASE && rerr_in) |=> $stable(used_ff))
      else $error("rejected release changed the bitmap");

endmodule

// ===== src/rx_slot_allocator.sv =====
// rx_slot_allocator: round-robin allocator over a ring of receive buffer slots
//
// Request channel: drive req_func and req_slot_index with start high; the
// transaction is taken at the clock edge where start is high and busy is low.
// req_func 0 allocates the first free slot at or after the search pointer
// (wrapping), 1 releases req_slot_index, 2 flushes every slot.
// Response channel: rsp_strobe is high for exactly one cycle with the result
// on the rsp_ ports; the receiver cannot stall it and must take it then.
// Sequencing: an allocate passes through the group search register, then
// commit, then the response strobe register; release, flush and the unused
// code skip the search. busy stays high until the commit is done, so a new
// transaction is not taken before the last one is committed; allocates take
// longer because of the two-level free-slot search.
// Reset (synchronous, active high) frees every slot, clears the search
// pointer and sets the free count to QUEUE_DEPTH; no sweep is needed.
module rx_slot_allocator
   import rsa_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_strobe,
   output logic               rsp_granted,
   output logic [SLOT_W-1:0]  rsp_granted_slot,
   output logic [COUNT_W-1:0] rsp_free_slots,
   output logic               rsp_release_error,
   output logic [COUNT_W-1:0] rsp_pending_before_flush
);

   rsa_cmd_type cmd;

   // sequencing
   rsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_func),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // bitmap, pointer, count and search
   rsa_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .req_func                 (req_func),
      .req_slot_index           (req_slot_index),
      .rsp_granted              (rsp_granted),
      .rsp_granted_slot         (rsp_granted_slot),
      .rsp_free_slots           (rsp_free_slots),
      .rsp_release_error        (rsp_release_error),
      .rsp_pending_before_flush (rsp_pending_before_flush)
   );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench
   import rsa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = DEFAULT_QUEUE_DEPTH;
   localparam int ITEMS      = 1650;
   localparam int IDLE_LIMIT = 1000;

   // code the block leaves unused, must act as a no-op
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic               granted;
      logic [SLOT_W-1:0]  granted_slot;
      logic [COUNT_W-1:0] free_slots;
      logic               release_error;
      logic [COUNT_W-1:0] pending_before_flush;
   } slot_result_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      int                reps;
      bit                typed;
      slot_result_type   want;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [FUNC_W-1:0]  req_func = FUNC_ALLOC;
   logic [SLOT_W-1:0]  req_slot_index = '0;
   logic               rsp_strobe;
   logic               rsp_granted;
   logic [SLOT_W-1:0]  rsp_granted_slot;
   logic [COUNT_W-1:0] rsp_free_slots;
   logic               rsp_release_error;
   logic [COUNT_W-1:0] rsp_pending_before_flush;

   // mirror of the allocator state
   logic [DEPTH-1:0]   used_map = '0;
   logic [SLOT_W-1:0]  search_ptr = '0;
   logic [COUNT_W-1:0] free_cnt = COUNT_W'(DEPTH);

   slot_result_type inflight_results[$];
   script_row_type  stim_script[$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   int n_sent = 0, n_granted = 0, n_denied = 0, n_released = 0;
   int n_rel_err = 0, n_flushes = 0, n_noops = 0;

   rx_slot_allocator DUT (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_func                 (req_func),
      .req_slot_index           (req_slot_index),
      .rsp_strobe               (rsp_strobe),
      .rsp_granted              (rsp_granted),
      .rsp_granted_slot         (rsp_granted_slot),
      .rsp_free_slots           (rsp_free_slots),
      .rsp_release_error        (rsp_release_error),
      .rsp_pending_before_flush (rsp_pending_before_flush)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one slot operation to the mirror and return its response
   function automatic slot_result_type next_slot_result(input logic [FUNC_W-1:0] f,
                                                        input logic [SLOT_W-1:0] s);
      slot_result_type r;
      int              idx;
      bit              found;
      r = '0;
      found = 1'b0;
      case (f)
         FUNC_ALLOC: begin
            // round-robin scan starting at the pointer itself
            for (int i = 0; i < DEPTH; i++) begin
               idx = (int'(search_ptr) + i) % DEPTH;
               if (!found && !used_map[idx]) begin
                  found = 1'b1;
                  used_map[idx] = 1'b1;
                  if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
                  search_ptr = SLOT_W'(idx);
                  r.granted = 1'b1;
                  r.granted_slot = SLOT_W'(idx);
               end
            end
            if (found) n_granted++;
            else n_denied++;
         end
         FUNC_RELEASE: begin
            if (int'(s) < DEPTH && used_map[s]) begin
               used_map[s] = 1'b0;
               if (free_cnt < COUNT_W'(DEPTH)) free_cnt = free_cnt + 1'b1;
               n_released++;
            end else begin
               r.release_error = 1'b1;
               n_rel_err++;
            end
         end
         FUNC_FLUSH: begin
            r.pending_before_flush = COUNT_W'($countones(used_map));
            used_map = '0;
            search_ptr = '0;
            free_cnt = COUNT_W'(DEPTH);
            n_flushes++;
         end
         default: n_noops++;
      endcase
      r.free_slots = free_cnt;
      return r;
   endfunction

   // a slot currently in use, searched from a random point; random if none
   function automatic logic [SLOT_W-1:0] pick_used_slot();
      int r;
      int idx;
      int hit;
      r = $urandom_range(0, DEPTH - 1);
      hit = r;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         idx = (r + i) % DEPTH;
         if (used_map[idx]) hit = idx;
      end
      return SLOT_W'(hit);
   endfunction

   task automatic add_row(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                          input int reps, input bit typed, input slot_result_type want);
      script_row_type row;
      row.func = f;
      row.slot = s;
      row.reps = reps;
      row.typed = typed;
      row.want = want;
      stim_script.push_back(row);
   endtask

   // send one transaction, with bursts and gaps on the request side
   task automatic issue(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                        input bit typed, input slot_result_type want);
      int              gap;
      slot_result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_func <= f;
      req_slot_index <= s;
      do @(posedge clock); while (busy);
      predicted = next_slot_result(f, s);
      inflight_results.push_back(typed ? want : predicted);
      n_sent++;
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      slot_result_type got;
      slot_result_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_strobe) begin
            got = '{rsp_granted, rsp_granted_slot, rsp_free_slots,
                    rsp_release_error, rsp_pending_before_flush};
            if (inflight_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with no transaction outstanding: %0d %0d %0d %0d %0d",
                           $realtime, got.granted, got.granted_slot, got.free_slots,
                           got.release_error, got.pending_before_flush);
               mismatches++;
            end else begin
               want = inflight_results.pop_front();
               if (got.granted !== want.granted || got.granted_slot !== want.granted_slot ||
                   got.free_slots !== want.free_slots ||
                   got.release_error !== want.release_error ||
                   got.pending_before_flush !== want.pending_before_flush) begin
                  if (mismatches < 10)
                     $display({"%0t: mismatch exp g=%0d s=%0d f=%0d e=%0d p=%0d",
                               " got g=%0d s=%0d f=%0d e=%0d p=%0d"},
                              $realtime, want.granted, want.granted_slot, want.free_slots,
                              want.release_error, want.pending_before_flush,
                              got.granted, got.granted_slot, got.free_slots,
                              got.release_error, got.pending_before_flush);
                  mismatches++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL rx_slot_allocator");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic [FUNC_W-1:0] f;
      logic [SLOT_W-1:0] s;
      int                alloc_pct;
      int                roll;
      alloc_pct = 50;

      // directed script: empty ring, full ring, wrap, flush extremes
      add_row(FUNC_RELEASE, 5'd0,  1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b1, 6'd0}));
      add_row(FUNC_RELEASE, 5'd31, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b1, 6'd0}));
      add_row(FUNC_UNUSED,  5'd31, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b0, 6'd0}));
      add_row(FUNC_FLUSH,   5'd0,  1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b0, 6'd0}));
      add_row(FUNC_ALLOC,   5'd31, 1, 1'b1,
              slot_result_type'({1'b1, 5'd0, 6'd31, 1'b0, 6'd0}));
      add_row(FUNC_ALLOC,   5'd0, 31, 1'b0, '0);
      // ring full: allocate denied, no-op reports zero free
      add_row(FUNC_ALLOC,   5'd0,  1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd0, 1'b0, 6'd0}));
      add_row(FUNC_UNUSED,  5'd0,  1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd0, 1'b0, 6'd0}));
      add_row(FUNC_RELEASE, 5'd31, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd1, 1'b0, 6'd0}));
      add_row(FUNC_RELEASE, 5'd31, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd1, 1'b1, 6'd0}));
      // pointer sits on the last slot, next search wraps through zero
      add_row(FUNC_ALLOC,   5'd0,  1, 1'b0, '0);
      add_row(FUNC_RELEASE, 5'd0,  1, 1'b0, '0);
      add_row(FUNC_RELEASE, 5'd5,  1, 1'b0, '0);
      add_row(FUNC_ALLOC,   5'd0,  2, 1'b0, '0);
      add_row(FUNC_RELEASE, 5'd16, 1, 1'b0, '0);
      add_row(FUNC_FLUSH,   5'd0,  1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b0, 6'd31}));
      add_row(FUNC_ALLOC,   5'd0,  1, 1'b1,
              slot_result_type'({1'b1, 5'd0, 6'd31, 1'b0, 6'd0}));
      add_row(FUNC_ALLOC,   5'd0, 31, 1'b0, '0);
      add_row(FUNC_FLUSH,   5'd31, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b0, 6'd32}));
      add_row(FUNC_RELEASE, 5'd21, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b1, 6'd0}));
      add_row(FUNC_RELEASE, 5'd10, 1, 1'b1,
              slot_result_type'({1'b0, 5'd0, 6'd32, 1'b1, 6'd0}));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_script[k])
         for (int j = 0; j < stim_script[k].reps; j++)
            issue(stim_script[k].func, stim_script[k].slot, stim_script[k].typed,
                  stim_script[k].want);

      // random traffic, fill pressure changes every phase
      for (int n = 0; n < ITEMS; n++) begin
         if (n % 110 == 0) alloc_pct = $urandom_range(25, 85);
         roll = $urandom_range(0, 999);
         s = SLOT_W'($urandom_range(0, DEPTH - 1));
         if (roll < 12) f = FUNC_FLUSH;
         else if (roll < 40) f = FUNC_UNUSED;
         else if (roll < 120) f = FUNC_RELEASE;
         else if (roll < 120 + alloc_pct * 880 / 100) f = FUNC_ALLOC;
         else begin
            f = FUNC_RELEASE;
            s = pick_used_slot();
         end
         issue(f, s, 1'b0, '0);
      end
      start <= 1'b0;

      // drain outstanding responses, then allow for stray strobes
      while (inflight_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d transactions: %0d grants, %0d denials on a full ring, %0d releases",
               n_sent, n_granted, n_denied, n_released);
      $display("%0d release errors, %0d flushes, %0d unused codes, %0d mismatches",
               n_rel_err, n_flushes, n_noops, mismatches);
      if (mismatches == 0)
         $display("PASS rx_slot_allocator");
      else
         $display("FAIL rx_slot_allocator");
      $finish;
   end

endmodule

// ===== files.f =====
src/rsa_pkg.sv
src/rsa_ctrl.sv
src/rsa_datapath.sv
src/rx_slot_allocator.sv
tb/sv/testbench.sv
